/* rtl/dda_pkg.sv */
// Package for the DDA line pixel generator: widths, counter sizes and the
// result structs passed from the square-root and divider units to the top level.
// No dependencies.
package dda_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 32;
  localparam int COLOUR_BITS = 32;

  localparam int POS_BITS  = COORD_BITS + FRAC_BITS;   // unsigned C.F position
  localparam int STEP_BITS = FRAC_BITS + 2;            // signed 1.F step
  localparam int QUOT_BITS = FRAC_BITS + 1;            // step magnitude, <= 1.0
  localparam int CNT_BITS  = COORD_BITS + 1;           // pixel count / sqrt root
  localparam int SQ_BITS   = 2 * COORD_BITS + 1;       // dx^2 + dy^2
  localparam int RAD_BITS  = 2 * CNT_BITS;             // radicand, even width

  localparam int SQ_ITERS  = CNT_BITS;                 // one root bit per cycle
  localparam int SQ_CNT_W  = $clog2(SQ_ITERS + 1);
  localparam int DIV_ITERS = COORD_BITS + FRAC_BITS;   // one quotient bit per cycle
  localparam int DIV_CNT_W = $clog2(DIV_ITERS + 1);

  // input transaction command codes
  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } dda_cmd_t;

  typedef struct packed {
    logic                done;
    logic [CNT_BITS-1:0] root;
  } dda_sqrt_res_t;

  typedef struct packed {
    logic                 done;
    logic [QUOT_BITS-1:0] quot;
  } dda_div_res_t;

endpackage

/* rtl/dda_sqrt.sv */
// Iterative integer floor square root, one root bit per cycle.
// Depends on dda_pkg.
module dda_sqrt import dda_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [SQ_BITS-1:0]  radicand,
  output dda_sqrt_res_t       res
);

  logic                busy_r;
  logic                done_r;
  logic [SQ_CNT_W-1:0] cnt_r;
  logic [RAD_BITS-1:0] rad_r;
  logic [CNT_BITS+1:0] rem_r;
  logic [CNT_BITS-1:0] root_r;

  logic [CNT_BITS+3:0] rem_sh;
  logic [CNT_BITS+3:0] trial;
  logic                take;

  always_comb begin
    rem_sh = {rem_r, rad_r[RAD_BITS-1 -: 2]};
    trial  = {2'b00, root_r, 2'b01};
    take   = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rad_r  <= {{(RAD_BITS-SQ_BITS){1'b0}}, radicand};
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        rad_r <= {rad_r[RAD_BITS-3:0], 2'b00};
        if (take) begin
          rem_r  <= CNT_BITS'(0) + (CNT_BITS+2)'(rem_sh - trial);
          root_r <= {root_r[CNT_BITS-2:0], 1'b1};
        end else begin
          rem_r  <= (CNT_BITS+2)'(rem_sh);
          root_r <= {root_r[CNT_BITS-2:0], 1'b0};
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == SQ_CNT_W'(SQ_ITERS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign res.done = done_r;
  assign res.root = root_r;

endmodule

/* rtl/dda_div.sv */
// Restoring divider, one quotient bit per cycle: (mag << FRAC_BITS) / divisor.
// Depends on dda_pkg.
module dda_div import dda_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [COORD_BITS-1:0] mag,
  input  logic [CNT_BITS-1:0]   divisor,
  output dda_div_res_t          res
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_ITERS-1:0] quo_r;    // dividend shifts out the top, quotient in
  logic [CNT_BITS-1:0]  rem_r;
  logic [CNT_BITS-1:0]  div_r;

  logic [CNT_BITS:0]    rem_sh;
  logic                 take;

  always_comb begin
    rem_sh = {rem_r, quo_r[DIV_ITERS-1]};
    take   = (rem_sh >= {1'b0, div_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        quo_r  <= {mag, {FRAC_BITS{1'b0}}};
        rem_r  <= '0;
        div_r  <= divisor;
      end else if (busy_r) begin
        if (take) begin
          rem_r <= CNT_BITS'(rem_sh - {1'b0, div_r});
          quo_r <= {quo_r[DIV_ITERS-2:0], 1'b1};
        end else begin
          rem_r <= CNT_BITS'(rem_sh);
          quo_r <= {quo_r[DIV_ITERS-2:0], 1'b0};
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_ITERS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign res.done = done_r;
  assign res.quot = quo_r[QUOT_BITS-1:0];

endmodule

/* rtl/dda_line_pixel_generator.sv */
// Top level of the DDA line pixel generator: load sequencer, position
// accumulators and output register. Depends on dda_pkg, dda_sqrt, dda_div.
//
//  channel | direction | ports                                         | handshake
//  --------+-----------+-----------------------------------------------+----------------------
//  in      | input     | in_command, in_start_x/y, in_end_x/y, colour  | in_valid / in_ready
//  out     | output    | out_pixel_x/y, out_pixel_colour, last_pixel   | out_valid / out_ready
//
// Steps can be accepted every cycle while the output register drains. A load
// holds the input from its accept edge to the next accept edge while the
// sequencer enters the root state, starts the root, runs the root, hands the
// root to the divider, divides for x, restarts the divider for y, divides for y
// and returns to idle; a zero-length line skips the divider. in_ready is low
// for the whole load.
// Reset (rst_n low, synchronous) clears the sequencer, the line state and the
// output valid. A stalled output holds its pixel; a new step is accepted in
// the cycle the held pixel is taken.
module dda_line_pixel_generator import dda_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_command,
  input  logic [COORD_BITS-1:0]  in_start_x,
  input  logic [COORD_BITS-1:0]  in_start_y,
  input  logic [COORD_BITS-1:0]  in_end_x,
  input  logic [COORD_BITS-1:0]  in_end_y,
  input  logic [COLOUR_BITS-1:0] in_line_colour,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [COORD_BITS-1:0]  out_pixel_x,
  output logic [COORD_BITS-1:0]  out_pixel_y,
  output logic [COLOUR_BITS-1:0] out_pixel_colour,
  output logic                   out_last_pixel
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQ_START,
    S_SQ_WAIT,
    S_DIVX_WAIT,
    S_DIVY_WAIT
  } state_t;

  state_t                 state_r;

  // line state
  logic [POS_BITS-1:0]    pos_x_r;
  logic [POS_BITS-1:0]    pos_y_r;
  logic [STEP_BITS-1:0]   step_dx_r;
  logic [STEP_BITS-1:0]   step_dy_r;
  logic [CNT_BITS-1:0]    pixels_left_r;
  logic [COLOUR_BITS-1:0] held_colour_r;

  // load working registers
  logic [COORD_BITS-1:0]  mag_x_r;
  logic [COORD_BITS-1:0]  mag_y_r;
  logic                   neg_x_r;
  logic                   neg_y_r;
  logic [CNT_BITS-1:0]    count_r;

  // output register
  logic                   out_valid_r;
  logic [COORD_BITS-1:0]  out_x_r;
  logic [COORD_BITS-1:0]  out_y_r;
  logic [COLOUR_BITS-1:0] out_colour_r;
  logic                   out_last_r;

  logic                   in_fire;
  logic                   load_fire;
  logic                   step_fire;
  logic                   emit;

  logic                   sq_start;
  logic [SQ_BITS-1:0]     sq_sum;
  dda_sqrt_res_t          sq_res;

  logic                   div_start;
  logic [COORD_BITS-1:0]  div_mag;
  logic [CNT_BITS-1:0]    div_divisor;
  dda_div_res_t           div_res;

  logic [STEP_BITS-1:0]   step_signed;
  logic                   neg_sel;

  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign load_fire = in_fire && (in_command == CMD_LOAD);
  assign step_fire = in_fire && (in_command == CMD_STEP);
  assign emit      = step_fire && (pixels_left_r != '0);

  // sum of squares feeds the root unit straight from the magnitude registers
  assign sq_sum   = SQ_BITS'(mag_x_r) * SQ_BITS'(mag_x_r)
                  + SQ_BITS'(mag_y_r) * SQ_BITS'(mag_y_r);
  assign sq_start = (state_r == S_SQ_START);

  // divider: x right after the root, y right after x
  always_comb begin
    div_start   = 1'b0;
    div_mag     = mag_x_r;
    div_divisor = count_r;
    if (state_r == S_SQ_WAIT && sq_res.done && sq_res.root != '0) begin
      div_start   = 1'b1;
      div_divisor = sq_res.root;
    end else if (state_r == S_DIVX_WAIT && div_res.done) begin
      div_start = 1'b1;
      div_mag   = mag_y_r;
    end
  end

  // apply the axis sign to the quotient, 1.F two's complement
  assign neg_sel     = (state_r == S_DIVX_WAIT) ? neg_x_r : neg_y_r;
  assign step_signed = neg_sel ? (STEP_BITS'(0) - {1'b0, div_res.quot})
                               : {1'b0, div_res.quot};

  dda_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sq_sum),
    .res      (sq_res)
  );

  dda_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .mag     (div_mag),
    .divisor (div_divisor),
    .res     (div_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      pos_x_r       <= '0;
      pos_y_r       <= '0;
      step_dx_r     <= '0;
      step_dy_r     <= '0;
      pixels_left_r <= '0;
      held_colour_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      // a pixel taken in the cycle a new one is emitted is refilled below
      if (out_valid_r && out_ready && !emit) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (load_fire) begin
            // new line replaces any line in progress
            mag_x_r       <= (in_end_x >= in_start_x) ? in_end_x - in_start_x
                                                      : in_start_x - in_end_x;
            mag_y_r       <= (in_end_y >= in_start_y) ? in_end_y - in_start_y
                                                      : in_start_y - in_end_y;
            neg_x_r       <= (in_end_x < in_start_x);
            neg_y_r       <= (in_end_y < in_start_y);
            pos_x_r       <= {in_start_x, {FRAC_BITS{1'b0}}};
            pos_y_r       <= {in_start_y, {FRAC_BITS{1'b0}}};
            held_colour_r <= in_line_colour;
            pixels_left_r <= '0;
            state_r       <= S_SQ_START;
          end else if (emit) begin
            out_valid_r   <= 1'b1;
            out_x_r       <= pos_x_r[POS_BITS-1 -: COORD_BITS];
            out_y_r       <= pos_y_r[POS_BITS-1 -: COORD_BITS];
            out_colour_r  <= held_colour_r;
            out_last_r    <= (pixels_left_r == CNT_BITS'(1));
            pos_x_r       <= pos_x_r + {{(POS_BITS-STEP_BITS){step_dx_r[STEP_BITS-1]}},
                                        step_dx_r};
            pos_y_r       <= pos_y_r + {{(POS_BITS-STEP_BITS){step_dy_r[STEP_BITS-1]}},
                                        step_dy_r};
            pixels_left_r <= pixels_left_r - 1'b1;
          end
        end
        S_SQ_START: begin
          state_r <= S_SQ_WAIT;
        end
        S_SQ_WAIT: begin
          if (sq_res.done) begin
            count_r <= sq_res.root;
            if (sq_res.root == '0) begin
              // zero-length line: no steps, no pixels
              step_dx_r <= '0;
              step_dy_r <= '0;
              state_r   <= S_IDLE;
            end else begin
              state_r <= S_DIVX_WAIT;
            end
          end
        end
        S_DIVX_WAIT: begin
          if (div_res.done) begin
            step_dx_r <= step_signed;
            state_r   <= S_DIVY_WAIT;
          end
        end
        S_DIVY_WAIT: begin
          if (div_res.done) begin
            step_dy_r     <= step_signed;
            pixels_left_r <= count_r;
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_x      = out_x_r;
  assign out_pixel_y      = out_y_r;
  assign out_pixel_colour = out_colour_r;
  assign out_last_pixel   = out_last_r;

  // no transaction accepted while a load is being worked out
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready)
    else $error("input ready during line set-up");

  // the final pixel empties the line and is flagged
  a_last_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && pixels_left_r == CNT_BITS'(1)) |=> (pixels_left_r == '0) && out_last_r)
    else $error("last pixel not flagged or line not emptied");

  // root unit finishes only while the sequencer waits for it
  a_sqrt_done: assert property (@(posedge clk) disable iff (!rst_n)
    sq_res.done |-> (state_r == S_SQ_WAIT))
    else $error("square root result outside its wait state");

  // divider finishes only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == S_DIVX_WAIT || state_r == S_DIVY_WAIT))
    else $error("divider result outside its wait states");

endmodule
